// ----- sv/scrq_pkg.sv -----
// ----------------------------------------------------------------------------
// scrq_pkg
// Shared types and constants of the scan request and countdown controller.
// ----------------------------------------------------------------------------
package scrq_pkg;

	// Opcodes of an input item
	localparam logic [1:0] OP_START    = 2'd0;
	localparam logic [1:0] OP_RESPONSE = 2'd1;
	localparam logic [1:0] OP_TICK     = 2'd2;

	// Event codes of a result item
	localparam logic [2:0] EV_NONE    = 3'd0;
	localparam logic [2:0] EV_REQUEST = 3'd1;
	localparam logic [2:0] EV_BEGIN   = 3'd2;
	localparam logic [2:0] EV_DONE    = 3'd3;
	localparam logic [2:0] EV_TIMEOUT = 3'd4;
	localparam logic [2:0] EV_ABORT   = 3'd5;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_WAIT_FRAMES = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_PER_STATION = 1'd1;

	// Reset values of the configuration registers
	localparam logic [9:0] WAIT_FRAMES_RST = 10'd10;
	localparam logic [7:0] FPS_RST         = 8'd4;

	// Transaction id wraps from this value back to one
	localparam logic [15:0] ID_MAX = 16'hFFFF;

	// Remainder unit: one dividend bit per step
	localparam int DIV_STEPS = 16;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [1:0]  opcode;
		logic [4:0]  station_count;
		logic        connected;
		logic [15:0] rsp_transaction_id;
		logic [15:0] rsp_scan_duration;
	} item_t;

	typedef struct packed {
		logic [2:0]  event_res;
		logic [15:0] transaction_id;
		logic [15:0] scan_duration;
		logic [4:0]  station_index;
		logic [15:0] not_listening_frames;
	} result_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] value;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic capture;
		logic div_step;
		logic commit;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic need_mod;
	} status_t;

endpackage

// ----- sv/scrq_chan_if.sv -----
// ----------------------------------------------------------------------------
// scrq_chan_if
// Valid/ready channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface scrq_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/scrq_rem.sv -----
// ----------------------------------------------------------------------------
// scrq_rem
// Bit-serial remainder unit: 16-bit dividend by 8-bit divisor, one bit a step.
// ----------------------------------------------------------------------------
module scrq_rem
	import scrq_pkg::*;
(
	input  logic        clk,
	input  logic        init,
	input  logic        step,
	input  logic [15:0] dividend,
	input  logic [7:0]  divisor,
	output logic [7:0]  rem
);

	logic [15:0] dvd_q;
	logic [7:0]  rem_q;
	logic [8:0]  trial;

	// shift in the next dividend bit, subtract when it fits
	assign trial = {rem_q, dvd_q[15]};

	always_ff @(posedge clk) begin
		if (init) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (step) begin
			dvd_q <= {dvd_q[14:0], 1'b0};
			if (trial >= {1'b0, divisor}) begin
				rem_q <= 8'(trial - {1'b0, divisor});
			end else begin
				rem_q <= trial[7:0];
			end
		end
	end

	assign rem = rem_q;

endmodule

// ----- sv/scrq_ctrl.sv -----
// ----------------------------------------------------------------------------
// scrq_ctrl
// Sequencer: accepts an item, runs the remainder unit when needed, commits.
// ----------------------------------------------------------------------------
module scrq_ctrl
	import scrq_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	output logic    result_valid,
	input  logic    result_ready,
	input  status_t sts,
	output cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_COMMIT
	} state_t;

	state_t            state_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	logic              out_free;

	assign out_free       = !out_valid_q || result_ready;
	assign item_ready     = (state_q == ST_IDLE);
	assign result_valid   = out_valid_q;
	assign cmd.capture    = (state_q == ST_IDLE) && item_valid;
	assign cmd.div_step   = (state_q == ST_CALC) && sts.need_mod;
	assign cmd.commit     = (state_q == ST_COMMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// load a fresh result, or drop the one just taken
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (item_valid) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					step_q <= STEP_W'(step_q + 1'b1);
					if (!sts.need_mod || step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/scrq_dp.sv -----
// ----------------------------------------------------------------------------
// scrq_dp
// Datapath: configuration, session state, item capture, result register.
// ----------------------------------------------------------------------------
module scrq_dp
	import scrq_pkg::*;
#(
	parameter int MAX_STATIONS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_we,
	input  cfg_t    cfg_data,
	input  item_t   item_data,
	input  cmd_t    cmd,
	output status_t sts,
	output result_t result_data
);

	localparam logic [7:0] MAX_ST = 8'(MAX_STATIONS);

	logic [9:0]  cfg_wait_q;
	logic [7:0]  cfg_fps_q;

	logic        busy_q, scanning_q;
	logic [15:0] last_id_q, active_id_q;
	logic        wait_act_q;     // response timer runs
	logic [9:0]  wait_left_q;
	logic [15:0] active_dur_q;
	logic        dur_neg_q;      // duration remainder is below zero
	logic [15:0] dur_left_q;
	logic [4:0]  stations_q, pos_q;

	item_t       item_q;
	result_t     result_q;
	logic [7:0]  rem;

	logic        n_busy, n_scanning, n_wait_act, n_dur_neg;
	logic [15:0] n_last_id, n_active_id, n_active_dur, n_dur_left, next_id;
	logic [9:0]  n_wait_left;
	logic [4:0]  n_stations, n_pos, cnt;
	logic [12:0] prod;
	result_t     res;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_wait_q <= WAIT_FRAMES_RST;
			cfg_fps_q  <= FPS_RST;
		end else if (cfg_we) begin
			unique case (cfg_data.index)
				CFG_WAIT_FRAMES:        cfg_wait_q <= cfg_data.value;
				CFG_FRAMES_PER_STATION: cfg_fps_q  <= cfg_data.value[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item_data;
		end
	end

	scrq_rem u_rem (
		.clk      (clk),
		.init     (cmd.capture),
		.step     (cmd.div_step),
		.dividend (dur_left_q),
		.divisor  (cfg_fps_q),
		.rem      (rem)
	);

	// the station step test only runs mid-scan with a positive remainder
	assign sts.need_mod = (item_q.opcode == OP_TICK) && scanning_q && !dur_neg_q &&
		(dur_left_q != '0) && (dur_left_q != active_dur_q) && (cfg_fps_q != '0);

	assign cnt     = ({3'b000, item_q.station_count} > MAX_ST) ? MAX_ST[4:0]
		: item_q.station_count;
	assign prod    = 13'(cnt) * 13'(cfg_fps_q);
	assign next_id = (last_id_q == ID_MAX) ? 16'd1 : 16'(last_id_q + 1'b1);

	always_comb begin
		n_busy       = busy_q;
		n_scanning   = scanning_q;
		n_last_id    = last_id_q;
		n_active_id  = active_id_q;
		n_wait_act   = wait_act_q;
		n_wait_left  = wait_left_q;
		n_active_dur = active_dur_q;
		n_dur_neg    = dur_neg_q;
		n_dur_left   = dur_left_q;
		n_stations   = stations_q;
		n_pos        = pos_q;
		res          = '0;
		res.event_res = EV_NONE;

		unique case (item_q.opcode)
			OP_START: begin
				if (busy_q) begin
					n_busy        = 1'b0;
					n_scanning    = 1'b0;
					n_wait_act    = 1'b0;
					n_dur_neg     = 1'b1;
					res.event_res = EV_ABORT;
				end else begin
					n_busy       = 1'b1;
					n_stations   = cnt;
					n_active_dur = 16'(prod);
					if (item_q.connected) begin
						n_last_id          = next_id;
						n_active_id        = next_id;
						n_wait_act         = 1'b1;
						n_wait_left        = cfg_wait_q;
						res.event_res      = EV_REQUEST;
						res.transaction_id = next_id;
						res.scan_duration  = 16'(prod);
					end else begin
						n_scanning = 1'b1;
						n_dur_left = 16'(prod);
						n_dur_neg  = 1'b0;
						n_pos      = '0;
					end
				end
			end
			OP_RESPONSE: begin
				if (wait_act_q && wait_left_q != '0 &&
					item_q.rsp_transaction_id == active_id_q) begin
					n_wait_act   = 1'b0;
					n_active_dur = item_q.rsp_scan_duration;
					n_stations   = cnt;
					n_scanning   = 1'b1;
					n_dur_left   = item_q.rsp_scan_duration;
					n_dur_neg    = 1'b0;
					n_pos        = '0;
				end
			end
			OP_TICK: begin
				if (!scanning_q && wait_act_q && wait_left_q == '0) begin
					n_wait_act    = 1'b0;
					n_busy        = 1'b0;
					n_scanning    = 1'b0;
					res.event_res = EV_TIMEOUT;
				end else if (wait_act_q && wait_left_q != '0) begin
					n_wait_left = 10'(wait_left_q - 1'b1);
				end
				if (scanning_q) begin
					if (!dur_neg_q && dur_left_q == active_dur_q) begin
						res.event_res            = EV_BEGIN;
						res.scan_duration        = active_dur_q;
						res.not_listening_frames = dur_left_q;
						n_dur_left = 16'(dur_left_q - 1'b1);
						n_dur_neg  = (dur_left_q == '0);
						if (pos_q < stations_q) begin
							n_pos = 5'(pos_q + 1'b1);
						end
					end else if (dur_neg_q || dur_left_q == '0) begin
						n_dur_neg         = 1'b1;
						n_busy            = 1'b0;
						n_scanning        = 1'b0;
						res.event_res     = EV_DONE;
						res.scan_duration = active_dur_q;
					end else begin
						if (cfg_fps_q != '0 && rem == '0 && pos_q < stations_q) begin
							n_pos = 5'(pos_q + 1'b1);
						end
						n_dur_left = 16'(dur_left_q - 1'b1);
					end
				end
			end
			default: ;
		endcase
		res.station_index = n_pos;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			scanning_q   <= 1'b0;
			last_id_q    <= '0;
			active_id_q  <= '0;
			wait_act_q   <= 1'b0;
			wait_left_q  <= '0;
			active_dur_q <= '0;
			dur_neg_q    <= 1'b1;
			dur_left_q   <= '0;
			stations_q   <= '0;
			pos_q        <= '0;
		end else if (cmd.commit) begin
			busy_q       <= n_busy;
			scanning_q   <= n_scanning;
			last_id_q    <= n_last_id;
			active_id_q  <= n_active_id;
			wait_act_q   <= n_wait_act;
			wait_left_q  <= n_wait_left;
			active_dur_q <= n_active_dur;
			dur_neg_q    <= n_dur_neg;
			dur_left_q   <= n_dur_left;
			stations_q   <= n_stations;
			pos_q        <= n_pos;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_q <= res;
		end
	end

	assign result_data = result_q;

endmodule

// ----- sv/scan_request_and_countdown_fsm.sv -----
// ----------------------------------------------------------------------------
// scan_request_and_countdown_fsm
// Subscriber-side scan controller: request, response timer and scan countdown.
// ----------------------------------------------------------------------------
// Usage:
//   item   - input channel, one opcode per transaction (start, response, tick).
//   result - output channel, exactly one result transaction per input item.
//   cfg    - register write channel, always ready; write only while idle.
// Sequencing:
//   A frame tick in the middle of a scan runs the bit-serial remainder unit
//   over all 16 dividend bits (one dividend bit per cycle) to test the
//   station step; every other item skips the remainder run. One item is
//   worked on at a time; the next is taken once the current result is in
//   the output register.
// Stall:
//   The output register holds the result while the receiver stalls; the
//   next item is still accepted and computed, and waits for the register.
// Reset:
//   arst_n clears the session, the timer and the scan, and loads the
//   register defaults (10 wait frames, 4 frames per station).
// ----------------------------------------------------------------------------
module scan_request_and_countdown_fsm
	import scrq_pkg::*;
#(
	parameter int MAX_STATIONS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	scrq_chan_if.sink   item,
	scrq_chan_if.source result,
	scrq_chan_if.sink   cfg
);

	cmd_t    cmd;
	status_t sts;
	item_t   item_data;
	cfg_t    cfg_data;
	result_t result_data;

	// registers take a write in any cycle
	assign cfg.ready = 1'b1;
	assign item_data = item.data;
	assign cfg_data  = cfg.data;
	assign result.data = result_data;

	// sequence each transaction: capture, optional remainder run, commit
	scrq_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_ready   (item.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.sts          (sts),
		.cmd          (cmd)
	);

	// hold the session state and build the result at commit
	scrq_dp #(
		.MAX_STATIONS (MAX_STATIONS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg.valid),
		.cfg_data    (cfg_data),
		.item_data   (item_data),
		.cmd         (cmd),
		.sts         (sts),
		.result_data (result_data)
	);

endmodule

// ----- sv/scrq_chk.sv -----
// ----------------------------------------------------------------------------
// scrq_chk
// Port-level checks of the scan controller, bound to the top level.
// ----------------------------------------------------------------------------
module scrq_chk
	import scrq_pkg::*;
#(
	parameter int MAX_STATIONS = 16
) (
	input logic    clk,
	input logic    arst_n,
	input logic    in_valid,
	input logic    in_ready,
	input logic    out_valid,
	input logic    out_ready,
	input result_t out_data
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// one transaction at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("item accepted while another is in flight");

	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 8'(out_data.station_index) <= 8'(MAX_STATIONS))
		else $error("station index beyond list bound");

	a_tid_only_request: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_res != EV_REQUEST |-> out_data.transaction_id == '0)
		else $error("transaction id outside a request");

	a_nlf_only_begin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_res != EV_BEGIN |-> out_data.not_listening_frames == '0)
		else $error("silent frames outside scan begin");

endmodule

bind scan_request_and_countdown_fsm scrq_chk #(
	.MAX_STATIONS (MAX_STATIONS)
) u_scrq_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (item.valid),
	.in_ready  (item.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_data  (result.data)
);
